// File: rtl/hss_pkg.sv
// Package: shared types and constants for the hash suppression set.
`default_nettype none
package hss_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned LIVE_W = 6;
  localparam int unsigned MAX_AW = 8;   // address field wide enough for 256 entries

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_ZERO    = 3'd1,
    ST_PRESENT = 3'd2,
    ST_FULL    = 3'd3,
    ST_ABSENT  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_MV_RD = 2'd2,
    S_MV_WR = 2'd3
  } state_e;

  // controller to key memory
  typedef struct packed {
    logic              rd_en;
    logic [MAX_AW-1:0] rd_addr;
    logic              we;
    logic [MAX_AW-1:0] wr_addr;
    logic [KEY_W-1:0]  wdata;
  } mem_req_t;

  // one result word
  typedef struct packed {
    logic              done;
    logic              hit;
    status_e           status;
    logic [LIVE_W-1:0] live_count;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/hss_key_mem.sv
// Key store: single-port-write, registered-read memory.
`default_nettype none
module hss_key_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic                  clk_i,
  input  wire hss_pkg::mem_req_t     req_i,
  output logic [hss_pkg::KEY_W-1:0]  rdata_o
);
  import hss_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_o <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

endmodule
`default_nettype wire

// File: rtl/hss_ctrl.sv
// Sequencer: clears, or scans the live prefix to append, swap or report.
`default_nettype none
module hss_ctrl #(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned CW       = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [hss_pkg::KEY_W-1:0] key_value_i,
  input  wire logic                  filter_i,
  input  wire logic [hss_pkg::KEY_W-1:0] rdata_i,
  output logic                       busy_o,
  output hss_pkg::mem_req_t          mem_o,
  output hss_pkg::result_t           res_o
);
  import hss_pkg::*;

  state_e           state_q, state_d;
  req_e             req_q, req_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    cmp_idx_q, cmp_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  result_t          res_q, res_d;

  logic          match;
  logic [CW-1:0] last;

  assign match  = cmp_vld_q && (rdata_i == key_q);
  assign last   = count_q - CW'(1);
  assign busy_o = (state_q != S_IDLE);
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    key_q     <= key_d;
    ptr_q     <= ptr_d;
    cmp_idx_q <= cmp_idx_d;
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    key_d     = key_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = 1'b0;
    res_d     = '0;
    res_d.status     = ST_DONE;
    res_d.live_count = LIVE_W'(count_q);
    mem_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_e'(req_type_i);
          key_d = key_value_i;
          ptr_d = '0;
          if (req_e'(req_type_i) == REQ_CLEAR) begin
            count_d          = '0;
            res_d.done       = 1'b1;
            res_d.live_count = '0;
          end else if (key_value_i == '0) begin
            res_d.done   = 1'b1;
            res_d.status = ST_ZERO;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (match) begin
          state_d    = S_IDLE;
          res_d.done = 1'b1;
          unique case (req_q)
            REQ_LOOKUP: res_d.hit = filter_i;
            REQ_INSERT: res_d.status = ST_PRESENT;
            REQ_REMOVE: begin
              if (cmp_idx_q != last) begin
                state_d    = S_MV_RD;
                res_d.done = 1'b0;
              end else begin
                count_d          = last;
                res_d.live_count = LIVE_W'(last);
              end
            end
            default: ;
          endcase
        end else if (ptr_q < count_q) begin
          // issue next read; compare lands next cycle
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = MAX_AW'(ptr_q);
          cmp_idx_d     = ptr_q;
          cmp_vld_d     = 1'b1;
          ptr_d         = ptr_q + CW'(1);
        end else begin
          // prefix exhausted, no match
          state_d    = S_IDLE;
          res_d.done = 1'b1;
          unique case (req_q)
            REQ_LOOKUP: ;
            REQ_INSERT: begin
              if (count_q >= CW'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                mem_o.we         = 1'b1;
                mem_o.wr_addr    = MAX_AW'(count_q);
                mem_o.wdata      = key_q;
                count_d          = count_q + CW'(1);
                res_d.live_count = LIVE_W'(count_q + CW'(1));
              end
            end
            REQ_REMOVE: res_d.status = ST_ABSENT;
            default: ;
          endcase
        end
      end

      S_MV_RD: begin
        mem_o.rd_en   = 1'b1;
        mem_o.rd_addr = MAX_AW'(last);
        state_d       = S_MV_WR;
      end

      S_MV_WR: begin
        mem_o.we         = 1'b1;
        mem_o.wr_addr    = MAX_AW'(cmp_idx_q);
        mem_o.wdata      = rdata_i;
        count_d          = last;
        res_d.done       = 1'b1;
        res_d.live_count = LIVE_W'(last);
        state_d          = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/hash_suppression_set.sv
// Top level: compacting membership set of 32-bit keys with swap-remove.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------------
//  request   req_type_i, key_value_i                 start_i & !busy_o
//  result    hit_o, status_o, live_count_o           done_o, one cycle, no stall
//  config    cfg_data_i (filter_enable)              cfg_valid_i & cfg_ready_o
//
// Cycles: clear and zero-key requests answer the cycle after start. Other
// requests walk the live prefix through the key memory's single read port,
// one entry per cycle; a remove that moves the last entry into the hole
// adds a read of that entry (S_MV_RD) and its write into the hole (S_MV_WR).
// Reset empties the set (count to zero) and clears filter_enable; the key
// memory itself is not cleared since only the live prefix is ever read.
// The result word is registered and the receiver cannot stall it.
`default_nettype none
module hash_suppression_set #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] key_value_i,
  output logic             done_o,
  output logic             hit_o,
  output logic [2:0]       status_o,
  output logic [5:0]       live_count_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);
  import hss_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic             filter_q;
  mem_req_t         mem_req;
  logic [KEY_W-1:0] mem_rdata;
  result_t          res;

  // config register is always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= 1'b0;
    end else if (cfg_valid_i) begin
      filter_q <= cfg_data_i;
    end
  end

  hss_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_type_i  (req_type_i),
    .key_value_i (key_value_i),
    .filter_i    (filter_q),
    .rdata_i     (mem_rdata),
    .busy_o      (busy_o),
    .mem_o       (mem_req),
    .res_o       (res)
  );

  hss_key_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign done_o       = res.done;
  assign hit_o        = res.hit;
  assign status_o     = res.status;
  assign live_count_o = res.live_count;

endmodule
`default_nettype wire

// File: tb/sv/hash_suppression_set_test.sv
// Testbench for hash_suppression_set: directed request table, then random phases checked by a predictor.
`default_nettype none
module hash_suppression_set_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hss_pkg::*;

  localparam int unsigned CAPACITY      = 32;
  localparam int unsigned KEY_POOL_SIZE = 48;   // more keys than slots, so the set can fill
  localparam int unsigned PHASES        = 9;
  localparam int unsigned PHASE_ITEMS   = 95;   // 9 x 95 ~ 850 random requests
  localparam int unsigned NUM_STEPS     = 26;

  // traffic mixes for the random phases
  localparam int MIX_FILL     = 0;
  localparam int MIX_BALANCED = 1;
  localparam int MIX_DRAIN    = 2;

  // one reply word as the block should present it
  typedef struct packed {
    logic              hit;
    status_e           status;
    logic [LIVE_W-1:0] live_count;
  } reply_t;

  // one row of the directed table: either a filter write or a request
  typedef struct packed {
    logic             cfg_write;
    logic             cfg_value;
    req_e             kind;
    logic [KEY_W-1:0] key;
    logic             typed;     // reply below is fixed; otherwise the predictor decides
    reply_t           reply;
  } step_t;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              start_i      = 1'b0;
  logic              busy_o;
  logic [1:0]        req_type_i   = REQ_LOOKUP;
  logic [KEY_W-1:0]  key_value_i  = '0;
  logic              done_o;
  logic              hit_o;
  logic [2:0]        status_o;
  logic [LIVE_W-1:0] live_count_o;
  logic              cfg_valid_i  = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_data_i   = 1'b0;

  hash_suppression_set #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .key_value_i (key_value_i),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .status_o    (status_o),
    .live_count_o(live_count_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("hash_suppression_set verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: live prefix of keys, live count, filter bit.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] stored_keys [CAPACITY];
  int unsigned      live_keys;
  logic             filter_on;

  logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
  reply_t           pending_replies [$];

  int unsigned fail_count;
  int unsigned requests_sent;
  int unsigned replies_seen;
  int unsigned hits_seen;
  int unsigned filter_writes;
  int unsigned status_tally [5];

  // Position of key in the live prefix, -1 when absent.
  function automatic int find_live(logic [KEY_W-1:0] key);
    for (int i = 0; i < live_keys; i++) begin
      if (stored_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the predicted set and return the reply it earns.
  function automatic reply_t apply_request(req_e kind, logic [KEY_W-1:0] key);
    reply_t r;
    int     at;
    r.hit    = 1'b0;
    r.status = ST_DONE;
    case (kind)
      REQ_LOOKUP: begin
        // presence is tested either way; only the filter lets it show as a hit
        if (key == '0) r.status = ST_ZERO;
        else if (filter_on && find_live(key) >= 0) r.hit = 1'b1;
      end
      REQ_INSERT: begin
        if (key == '0) r.status = ST_ZERO;
        else if (find_live(key) >= 0) r.status = ST_PRESENT;
        else if (live_keys >= CAPACITY) r.status = ST_FULL;
        else begin
          stored_keys[live_keys] = key;
          live_keys++;
        end
      end
      REQ_REMOVE: begin
        if (key == '0) r.status = ST_ZERO;
        else begin
          at = find_live(key);
          if (at < 0) r.status = ST_ABSENT;
          else begin
            // swap-remove: last live entry fills the hole
            if (at != live_keys - 1) stored_keys[at] = stored_keys[live_keys - 1];
            live_keys--;
          end
        end
      end
      default: live_keys = 0;   // clear: entries stay in the store but drop out of the prefix
    endcase
    r.live_count = live_keys[LIVE_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Reply checker. Replies cannot be held off, so every strobe is taken.
  // Sampled at the edge, so the values are those of the ending cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply word: hit=%0b status=%0d count=%0d",
                 $time, hit_o, status_o, live_count_o);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        replies_seen++;
        if (hit_o !== want.hit) begin
          $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, hit_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status_o);
          fail_count++;
        end
        if (live_count_o !== want.live_count) begin
          $display("%0t: live_count mismatch: expected %0d, actual %0d",
                   $time, want.live_count, live_count_o);
          fail_count++;
        end
        if (hit_o === 1'b1) hits_seen++;
        if (status_o < 3'd5) status_tally[status_o]++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. All drives are nonblocking at the rising edge.
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the block takes it (start & !busy).
  task automatic send_request(req_e kind, logic [KEY_W-1:0] key, logic typed,
                              reply_t fixed_reply);
    reply_t predicted;
    req_type_i  <= kind;
    key_value_i <= key;
    start_i     <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    predicted = apply_request(kind, key);
    pending_replies.push_back(typed ? fixed_reply : predicted);
    requests_sent++;
  endtask

  task automatic pause_requests(int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stop issuing and wait for every outstanding reply.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // Filter register is only touched with the block idle.
  task automatic write_filter(logic value);
    wait_drained();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    filter_on = value;
    filter_writes++;
  endtask

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Key choice: a few zeros, live keys for hits and removes, the shared pool
  // for duplicates and fills, and fully random words for bit coverage.
  // 'fresh' skips the live keys so inserts mostly land.
  function automatic logic [KEY_W-1:0] pick_key(bit fresh);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (!fresh && r < 45 && live_keys > 0) return stored_keys[$urandom_range(0, live_keys - 1)];
    if (r < 80) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic run_phase(int mix, bit burst);
    int               r;
    req_e             kind;
    logic [KEY_W-1:0] key;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:     kind = (r < 75) ? REQ_INSERT : (r < 90) ? REQ_LOOKUP :
                             (r < 98) ? REQ_REMOVE : REQ_CLEAR;
        MIX_DRAIN:    kind = (r < 55) ? REQ_REMOVE : (r < 80) ? REQ_LOOKUP :
                             (r < 97) ? REQ_INSERT : REQ_CLEAR;
        default:      kind = (r < 35) ? REQ_LOOKUP : (r < 65) ? REQ_INSERT :
                             (r < 95) ? REQ_REMOVE : REQ_CLEAR;
      endcase
      key = pick_key(mix == MIX_FILL && kind == REQ_INSERT);
      send_request(kind, key, 1'b0, '0);
      if (!burst) pause_requests(pick_gap());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Fixed replies only where they are obvious: empty set,
  // zero keys, error codes, the all-ones key. Swap-removes go to the predictor.
  // ---------------------------------------------------------------------------
  step_t directed_steps [NUM_STEPS] = '{
    // empty set, filter off after reset
    '{1'b0, 1'b0, REQ_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, ST_ZERO,    6'd0}},
    '{1'b0, 1'b0, REQ_INSERT, 32'h0000_0000, 1'b1, '{1'b0, ST_ZERO,    6'd0}},
    '{1'b0, 1'b0, REQ_REMOVE, 32'h0000_0000, 1'b1, '{1'b0, ST_ZERO,    6'd0}},
    '{1'b0, 1'b0, REQ_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b0, ST_ABSENT,  6'd0}},
    '{1'b0, 1'b0, REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b0, ST_DONE,    6'd0}},
    '{1'b0, 1'b0, REQ_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b0, ST_DONE,    6'd1}},
    '{1'b0, 1'b0, REQ_INSERT, 32'h0000_0001, 1'b1, '{1'b0, ST_DONE,    6'd2}},
    '{1'b0, 1'b0, REQ_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b0, ST_PRESENT, 6'd2}},
    // present key, but filter still off
    '{1'b0, 1'b0, REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b0, ST_DONE,    6'd2}},
    '{1'b1, 1'b1, REQ_LOOKUP, 32'h0000_0000, 1'b0, '{1'b0, ST_DONE,    6'd0}},
    '{1'b0, 1'b0, REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b1, ST_DONE,    6'd2}},
    '{1'b0, 1'b0, REQ_LOOKUP, 32'h0000_0001, 1'b1, '{1'b1, ST_DONE,    6'd2}},
    '{1'b0, 1'b0, REQ_LOOKUP, 32'h8000_0000, 1'b1, '{1'b0, ST_DONE,    6'd2}},
    '{1'b0, 1'b0, REQ_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, ST_ZERO,    6'd2}},
    // remove from the front moves the last entry into the hole
    '{1'b0, 1'b0, REQ_INSERT, 32'h8000_0000, 1'b0, '{1'b0, ST_DONE,    6'd0}},
    '{1'b0, 1'b0, REQ_REMOVE, 32'hFFFF_FFFF, 1'b0, '{1'b0, ST_DONE,    6'd0}},
    '{1'b0, 1'b0, REQ_LOOKUP, 32'h8000_0000, 1'b0, '{1'b0, ST_DONE,    6'd0}},
    '{1'b0, 1'b0, REQ_REMOVE, 32'h8000_0000, 1'b0, '{1'b0, ST_DONE,    6'd0}},
    // remove of the last entry itself, then of a key already gone
    '{1'b0, 1'b0, REQ_REMOVE, 32'h0000_0001, 1'b0, '{1'b0, ST_DONE,    6'd0}},
    '{1'b0, 1'b0, REQ_REMOVE, 32'h0000_0001, 1'b1, '{1'b0, ST_ABSENT,  6'd0}},
    // clear ignores its key; cleared entries no longer match
    '{1'b0, 1'b0, REQ_INSERT, 32'h1234_5678, 1'b0, '{1'b0, ST_DONE,    6'd0}},
    '{1'b0, 1'b0, REQ_INSERT, 32'hEDCB_A987, 1'b0, '{1'b0, ST_DONE,    6'd0}},
    '{1'b0, 1'b0, REQ_CLEAR,  32'hA5A5_A5A5, 1'b1, '{1'b0, ST_DONE,    6'd0}},
    '{1'b0, 1'b0, REQ_LOOKUP, 32'h1234_5678, 1'b1, '{1'b0, ST_DONE,    6'd0}},
    '{1'b1, 1'b0, REQ_LOOKUP, 32'h0000_0000, 1'b0, '{1'b0, ST_DONE,    6'd0}},
    '{1'b0, 1'b0, REQ_CLEAR,  32'h0000_0000, 1'b1, '{1'b0, ST_DONE,    6'd0}}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int mix;
    live_keys  = 0;
    filter_on  = 1'b0;
    fail_count = 0;
    foreach (stored_keys[i]) stored_keys[i] = '0;
    foreach (key_pool[i]) begin
      do key_pool[i] = $urandom; while (key_pool[i] == '0);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].cfg_write) begin
        write_filter(directed_steps[i].cfg_value);
      end else begin
        send_request(directed_steps[i].kind, directed_steps[i].key,
                     directed_steps[i].typed, directed_steps[i].reply);
        pause_requests(pick_gap());
      end
    end

    // Random phases: filter on for the first phase, a fill, so hits show on a
    // full set; off for the second phase, random after that. The fifth phase runs without gaps.
    for (int p = 0; p < PHASES; p++) begin
      write_filter(p == 0 ? 1'b1 : p == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      mix = (p % 3 == 0) ? MIX_FILL : (p % 3 == 1) ? MIX_BALANCED : MIX_DRAIN;
      run_phase(mix, p == 4);
    end

    wait_drained();
    repeat (CAPACITY + 16) @(posedge clk_i);

    $display("Covered %0d requests (%0d replies, %0d lookup hits, %0d filter writes).",
             requests_sent, replies_seen, hits_seen, filter_writes);
    $display("Status counts: done %0d, zero key %0d, present %0d, full %0d, not found %0d.",
             status_tally[ST_DONE], status_tally[ST_ZERO], status_tally[ST_PRESENT],
             status_tally[ST_FULL], status_tally[ST_ABSENT]);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("hash_suppression_set verification clean");
    end else begin
      $display("hash_suppression_set verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: hash_suppression_set.f
rtl/hss_pkg.sv
rtl/hss_key_mem.sv
rtl/hss_ctrl.sv
rtl/hash_suppression_set.sv
tb/sv/hash_suppression_set_test.sv
